### src/h2r_pkg.sv
// shared constants for the hsl to rgb converter
package h2r_pkg;

    localparam int NUM_CHAN = 3;
    localparam int CHAN_W = 8;
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;
    localparam int QUEUE_AW = 2;

endpackage

### src/hsl_to_rgb_converter.sv
// top level of the hsl to rgb pixel converter
// an accepted pixel passes the front register, the fifo, back stages r1 to r6 and the output register
// throughput: one item per cycle while the output is not stalled, set by the fully pipelined back stages
// a 4-entry fifo between front and back absorbs output stalls
// reset: synchronous active-low, clears valid flags, fifo pointers and fifo count only
module hsl_to_rgb_converter #(
    parameter int FRAC_BITS = 12
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // hue, saturation, lightness, zero padding
    input  logic [((3*(FRAC_BITS+1)+7)/8)*8-1:0] i_s_tdata,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // red, green, blue
    output logic [h2r_pkg::NUM_CHAN*h2r_pkg::CHAN_W-1:0] o_m_tdata
);
    import h2r_pkg::*;

    localparam int W = FRAC_BITS + 1;
    localparam int ITEM_W = (NUM_CHAN + 2) * W;

    logic              push_valid;
    logic              push_ready;
    logic [ITEM_W-1:0] push_item;
    logic              pop_valid;
    logic              pop_ready;
    logic [ITEM_W-1:0] pop_item;

    h2r_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_hue        (i_s_tdata[W-1:0]),
        .i_saturation (i_s_tdata[2*W-1:W]),
        .i_lightness  (i_s_tdata[3*W-1:2*W]),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_item  (push_item)
    );

    h2r_queue #(
        .WIDTH(ITEM_W)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (push_valid),
        .o_wr_ready (push_ready),
        .i_wr_data  (push_item),
        .o_rd_valid (pop_valid),
        .i_rd_ready (pop_ready),
        .o_rd_data  (pop_item)
    );

    h2r_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (pop_valid),
        .o_item_ready (pop_ready),
        .i_item       (pop_item),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata)
    );

endmodule

### src/h2r_front.sv
// front stage: input clamp, per-channel hue offset, wrap and ramp segment select
module h2r_front #(
    parameter int FRAC_BITS = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [FRAC_BITS:0]             i_hue,
    input  logic [FRAC_BITS:0]             i_saturation,
    input  logic [FRAC_BITS:0]             i_lightness,
    output logic                           o_push_valid,
    input  logic                           i_push_ready,
    output logic [(h2r_pkg::NUM_CHAN+2)*(FRAC_BITS+1)-1:0] o_push_item
);
    import h2r_pkg::*;

    localparam int W = FRAC_BITS + 1;
    localparam int VW = FRAC_BITS + 4;
    localparam int UW = FRAC_BITS + 2;
    localparam int DW = FRAC_BITS + 3;
    localparam int ITEM_W = (NUM_CHAN + 2) * W;

    localparam logic [W-1:0] ONE_W = W'(64'd1 << FRAC_BITS);
    localparam logic signed [VW-1:0] ONE_S = VW'(64'd1 << FRAC_BITS);
    localparam logic signed [VW-1:0] FULL_S = VW'(64'd3 << FRAC_BITS);
    localparam logic [DW-1:0] ONE_D = DW'(64'd1 << FRAC_BITS);
    localparam logic [DW-1:0] THREE_D = DW'(64'd3 << FRAC_BITS);
    localparam logic [UW-1:0] TWO_U = UW'(64'd2 << FRAC_BITS);

    logic              r_valid;
    logic [ITEM_W-1:0] r_item;
    logic [ITEM_W-1:0] n_item;

    logic [W-1:0]            hue_c;
    logic [W-1:0]            sat_c;
    logic [W-1:0]            light_c;
    logic signed [VW-1:0]    h3;
    logic signed [VW-1:0]    v_off [NUM_CHAN];
    logic signed [VW-1:0]    v_wrap [NUM_CHAN];
    logic [UW-1:0]           v_u [NUM_CHAN];
    logic [DW-1:0]           v2 [NUM_CHAN];
    logic [UW-1:0]           fall [NUM_CHAN];
    logic [W-1:0]            t_val [NUM_CHAN];

    assign o_s_tready = !r_valid || i_push_ready;
    assign o_push_valid = r_valid;
    assign o_push_item = r_item;

    always_comb begin
        hue_c = (i_hue > ONE_W) ? ONE_W : i_hue;
        sat_c = (i_saturation > ONE_W) ? ONE_W : i_saturation;
        light_c = (i_lightness > ONE_W) ? ONE_W : i_lightness;
        h3 = signed'(VW'(hue_c)) + (signed'(VW'(hue_c)) <<< 1);
        n_item = '0;
        n_item[W-1:0] = light_c;
        n_item[2*W-1:W] = sat_c;
        for (int c = 0; c < NUM_CHAN; c++) begin
            // red leads green by a third of a turn, blue trails it
            if (c == 0) begin
                v_off[c] = h3 + ONE_S;
            end else if (c == 1) begin
                v_off[c] = h3;
            end else begin
                v_off[c] = h3 - ONE_S;
            end
            priority if (v_off[c] < 0) begin
                v_wrap[c] = v_off[c] + FULL_S;
            end else if (v_off[c] > FULL_S) begin
                v_wrap[c] = v_off[c] - FULL_S;
            end else begin
                v_wrap[c] = v_off[c];
            end
            v_u[c] = v_wrap[c][UW-1:0];
            v2[c] = {v_u[c], 1'b0};
            fall[c] = TWO_U - v_u[c];
            priority if (v2[c] < ONE_D) begin
                t_val[c] = v2[c][W-1:0];
            end else if (v2[c] < THREE_D) begin
                t_val[c] = ONE_W;
            end else if (v_u[c] < TWO_U) begin
                t_val[c] = {fall[c][FRAC_BITS-1:0], 1'b0};
            end else begin
                t_val[c] = '0;
            end
            n_item[(c+2)*W +: W] = t_val[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_item <= n_item;
        end
    end

endmodule

### src/h2r_queue.sv
// small fifo between the front and back stages
module h2r_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_valid,
    output logic             o_wr_ready,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_rd_valid,
    input  logic             i_rd_ready,
    output logic [WIDTH-1:0] o_rd_data
);
    import h2r_pkg::*;

    localparam int DEPTH = 1 << QUEUE_AW;
    localparam logic [QUEUE_AW:0] DEPTH_C = (QUEUE_AW+1)'(DEPTH);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                do_wr;
    logic                do_rd;

    assign o_wr_ready = r_count != DEPTH_C;
    assign o_rd_valid = r_count != '0;
    assign o_rd_data = r_mem[r_rd_ptr];
    assign do_wr = i_wr_valid && o_wr_ready;
    assign do_rd = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

### src/h2r_back.sv
// back pipeline: helper levels, ramp products, scale by 255 and saturate
module h2r_back #(
    parameter int FRAC_BITS = 12
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_item_valid,
    output logic o_item_ready,
    input  logic [(h2r_pkg::NUM_CHAN+2)*(FRAC_BITS+1)-1:0] i_item,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    output logic [h2r_pkg::NUM_CHAN*h2r_pkg::CHAN_W-1:0] o_m_tdata
);
    import h2r_pkg::*;

    localparam int F = FRAC_BITS;
    localparam int W = F + 1;
    localparam int HW = 2 * F + 1;
    localparam int XW = 2 * F + 2;
    localparam int CW = 2 * F + 9;
    localparam int SW = 2 * F + 10;
    localparam int NSTG = 6;

    localparam logic [W-1:0] HALF_W = W'(64'd1 << (F - 1));

    logic              en;
    logic [NSTG-1:0]   r_vld;
    logic              r_out_vld;
    logic [NUM_CHAN*CHAN_W-1:0] r_out_data;
    logic [NUM_CHAN*CHAN_W-1:0] n_out_data;

    logic [W-1:0]  in_l;
    logic [W-1:0]  in_s;
    logic [W-1:0]  in_t [NUM_CHAN];

    logic [W-1:0]  r1_l;
    logic [W-1:0]  r1_s;
    logic [2*W-1:0] r1_p;
    logic [W-1:0]  r1_t [NUM_CHAN];

    logic [XW-1:0] n2_hi;
    logic [HW-1:0] r2_hi;
    logic [XW-1:0] r2_lsh2;
    logic [W-1:0]  r2_t [NUM_CHAN];

    logic [XW-1:0] n3_lo;
    logic [XW-1:0] n3_d;
    logic [HW-1:0] r3_lo;
    logic [F:0]    r3_dh;
    logic [F-1:0]  r3_dl;
    logic [W-1:0]  r3_t [NUM_CHAN];

    logic [HW-1:0] r4_lo;
    logic [XW-1:0] r4_mh [NUM_CHAN];
    logic [HW-1:0] r4_ml [NUM_CHAN];

    logic [CW-1:0] n5_c [NUM_CHAN];
    logic [XW-1:0] r5_a [NUM_CHAN];
    logic [F+8:0]  r5_c [NUM_CHAN];

    logic [SW-1:0] r6_a255 [NUM_CHAN];
    logic [F+8:0]  r6_c [NUM_CHAN];

    logic [SW-1:0] n_sum [NUM_CHAN];
    logic [9:0]    n_lvl [NUM_CHAN];

    assign en = !r_out_vld || i_m_tready;
    assign o_item_ready = en;
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata = r_out_data;

    always_comb begin
        in_l = i_item[W-1:0];
        in_s = i_item[2*W-1:W];
        for (int c = 0; c < NUM_CHAN; c++) begin
            in_t[c] = i_item[(c+2)*W +: W];
        end
        // upper helper level at scale one squared
        if (r1_l < HALF_W) begin
            n2_hi = (XW'(r1_l) << F) + XW'(r1_p);
        end else begin
            n2_hi = ((XW'(r1_l) + XW'(r1_s)) << F) - XW'(r1_p);
        end
        n3_lo = r2_lsh2 - XW'(r2_hi);
        n3_d = (XW'(r2_hi) << 1) - r2_lsh2;
        n_out_data = '0;
        for (int c = 0; c < NUM_CHAN; c++) begin
            n5_c[c] = (CW'(r4_ml[c]) << 8) - CW'(r4_ml[c]);
            n_sum[c] = r6_a255[c] + SW'(r6_c[c]);
            n_lvl[c] = n_sum[c][SW-1:2*F];
            n_out_data[c*CHAN_W +: CHAN_W] =
                (n_lvl[c] > 10'(CHAN_MAX)) ? CHAN_MAX : n_lvl[c][CHAN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_item_valid};
            r_out_vld <= r_vld[NSTG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_l <= in_l;
            r1_s <= in_s;
            r1_p <= (2*W)'(in_l) * (2*W)'(in_s);
            r2_hi <= n2_hi[HW-1:0];
            r2_lsh2 <= XW'(r1_l) << (F + 1);
            r3_lo <= n3_lo[HW-1:0];
            r3_dh <= n3_d[2*F:F];
            r3_dl <= n3_d[F-1:0];
            r4_lo <= r3_lo;
            for (int c = 0; c < NUM_CHAN; c++) begin
                r1_t[c] <= in_t[c];
                r2_t[c] <= r1_t[c];
                r3_t[c] <= r2_t[c];
                r4_mh[c] <= XW'(r3_dh) * XW'(r3_t[c]);
                r4_ml[c] <= HW'(r3_dl) * HW'(r3_t[c]);
                r5_a[c] <= XW'(r4_lo) + r4_mh[c];
                r5_c[c] <= n5_c[c][CW-1:F];
                r6_a255[c] <= (SW'(r5_a[c]) << 8) - SW'(r5_a[c]);
                r6_c[c] <= r5_c[c];
            end
            r_out_data <= n_out_data;
        end
    end

endmodule

### tb/tb_hsl_to_rgb_converter.sv
// testbench for the hsl to rgb converter: random and corner pixels against a predictor
`timescale 1ns / 1ps

module tb_hsl_to_rgb_converter;

    localparam int FB = 12;
    localparam int IN_W = ((3*(FB+1)+7)/8)*8;
    localparam int OUT_W = h2r_pkg::NUM_CHAN*h2r_pkg::CHAN_W;
    localparam longint unsigned UNITY = 64'd1 << FB;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 30;
    localparam int RANDOM_PER_PHASE = 150;

    typedef struct packed {
        logic [FB:0] lightness;
        logic [FB:0] saturation;
        logic [FB:0] hue;
    } t_hsl_item;

    typedef struct packed {
        logic [h2r_pkg::CHAN_W-1:0] blue;
        logic [h2r_pkg::CHAN_W-1:0] green;
        logic [h2r_pkg::CHAN_W-1:0] red;
    } t_rgb;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    // hue, saturation, lightness, zero padding
    logic [IN_W-1:0] i_s_tdata = '0;
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    // red, green, blue
    logic [OUT_W-1:0] o_m_tdata;

    t_hsl_item pending_pixels[$];
    t_rgb expected_rgb[$];
    int src_gap_pct = 0;
    int sink_stall_pct = 0;
    int err_count = 0;
    int pixels_sent = 0;
    int pixels_checked = 0;
    int idle_cycles = 0;

    hsl_to_rgb_converter #(.FRAC_BITS(FB)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic longint unsigned clip_unit(logic [FB:0] x);
        return (x > UNITY) ? UNITY : longint'(x);
    endfunction

    function automatic logic [7:0] clip_byte(longint unsigned x);
        return (x > 255) ? 8'd255 : x[7:0];
    endfunction

    // 255 * (lo + (hi - lo) * t / unity) at scale unity^2, truncated
    function automatic longint unsigned blend_level(longint unsigned lo, longint unsigned hi,
                                                    longint unsigned t);
        longint unsigned diff, d_hi, d_lo, a, b;
        diff = hi - lo;
        d_hi = diff >> FB;
        d_lo = diff & (UNITY - 1);
        a = lo + d_hi * t;
        b = d_lo * t;
        return (255 * a + ((255 * b) >> FB)) >> (2*FB);
    endfunction

    // hue position held at scale 3*unity
    function automatic logic [7:0] hue_channel(longint unsigned lo, longint unsigned hi,
                                               longint pos);
        longint one, full;
        one = longint'(UNITY);
        full = 3 * one;
        if (pos < 0) pos += full;
        if (pos > full) pos -= full;
        if (2 * pos < one) return clip_byte(blend_level(lo, hi, longint'(2 * pos)));
        if (2 * pos < full) return clip_byte((hi * 255) >> (2*FB));
        if (pos < 2 * one) return clip_byte(blend_level(lo, hi, longint'(2 * (2 * one - pos))));
        return clip_byte((lo * 255) >> (2*FB));
    endfunction

    function automatic t_rgb predict_rgb(t_hsl_item px);
        longint unsigned h, s, l, hi, lo;
        longint h3;
        t_rgb res;
        h = clip_unit(px.hue);
        s = clip_unit(px.saturation);
        l = clip_unit(px.lightness);
        if (s == 0) begin
            res.red = clip_byte((l * 255) >> FB);
            res.green = res.red;
            res.blue = res.red;
            return res;
        end
        if (2 * l < UNITY) hi = l * (UNITY + s);
        else hi = (l + s) * UNITY - s * l;
        lo = 2 * l * UNITY - hi;
        h3 = 3 * longint'(h);
        res.red = hue_channel(lo, hi, h3 + longint'(UNITY));
        res.green = hue_channel(lo, hi, h3);
        res.blue = hue_channel(lo, hi, h3 - longint'(UNITY));
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        err_count++;
    endtask

    function automatic logic [FB:0] rand_field();
        int k;
        longint unsigned v;
        v = 0;
        case ($urandom_range(11))
            0: v = longint'($urandom);
            1: v = 0;
            2: v = UNITY;
            3: begin
                k = int'($urandom_range(6));
                v = (k * UNITY / 6) + $urandom_range(4) - 2 + ((k == 0) ? 2 : 0);
            end
            default: v = longint'($urandom_range(int'(UNITY)));
        endcase
        return v[FB:0];
    endfunction

    task automatic push_pixel(int h, int s, int l);
        t_hsl_item px;
        px.hue = h[FB:0];
        px.saturation = s[FB:0];
        px.lightness = l[FB:0];
        pending_pixels.push_back(px);
    endtask

    task automatic wait_drained();
        while (pending_pixels.size() != 0 || i_s_tvalid) @(posedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_pixels.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
                    i_s_tdata <= IN_W'(pending_pixels.pop_front());
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        t_rgb got, want;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                expected_rgb.push_back(predict_rgb(t_hsl_item'(i_s_tdata[3*(FB+1)-1:0])));
                pixels_sent++;
            end
            if (o_m_tvalid && i_m_tready) begin
                got = t_rgb'(o_m_tdata);
                if (expected_rgb.size() == 0) begin
                    report_mismatch("result with no pixel pending");
                end else begin
                    want = expected_rgb.pop_front();
                    pixels_checked++;
                    if (got.red != want.red)
                        report_mismatch($sformatf("red got %0d expected %0d",
                                                  got.red, want.red));
                    if (got.green != want.green)
                        report_mismatch($sformatf("green got %0d expected %0d",
                                                  got.green, want.green));
                    if (got.blue != want.blue)
                        report_mismatch($sformatf("blue got %0d expected %0d",
                                                  got.blue, want.blue));
                end
            end
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", idle_cycles);
                $display("DONE: errors detected");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners
        push_pixel(0, 0, 0);
        push_pixel(0, 0, int'(UNITY));
        push_pixel(1000, 0, 2048);
        push_pixel(0, int'(UNITY), 2048);
        push_pixel(int'(UNITY), int'(UNITY), 2048);
        push_pixel(int'(UNITY), 2000, 1500);
        push_pixel(1365, 3000, 2047);
        push_pixel(1366, 3000, 2048);
        push_pixel(682, 4000, 1000);
        push_pixel(683, 4000, 3000);
        push_pixel(2048, 2500, 2500);
        push_pixel(2730, 1234, 2049);
        push_pixel(2731, 1234, 2046);
        push_pixel(3413, 4096, 4096);
        push_pixel(3414, 1, 1);
        push_pixel(8191, 2000, 2000);
        push_pixel(1000, 8191, 2000);
        push_pixel(1000, 2000, 8191);
        push_pixel(8191, 8191, 8191);
        push_pixel(4097, 4097, 4097);
        push_pixel(5461, 6000, 1);
        push_pixel(1, int'(UNITY), int'(UNITY));
        push_pixel(4095, 4095, 4095);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_gap_pct = 0; sink_stall_pct = 0; end
                1: begin src_gap_pct = 53; sink_stall_pct = 0; end
                2: begin src_gap_pct = 0; sink_stall_pct = 53; end
                default: begin src_gap_pct = 38; sink_stall_pct = 38; end
            endcase
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                push_pixel(int'(rand_field()), int'(rand_field()), int'(rand_field()));
            end
            wait_drained();
        end

        while (expected_rgb.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d pixels, %0d results checked", pixels_sent, pixels_checked);
        $display("phases: free flow, source gaps, sink stalls, both; %0d errors", err_count);
        if (err_count == 0 && expected_rgb.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
